### src/i2cm_pkg.sv
// shared types, opcode codes and sequence lengths for the i2c master bit engine
package i2cm_pkg;

  // opcode codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned TPA_W      = 16;
  localparam logic [TPA_W-1:0] TPA_RESET = 16'd720;

  // one classified tick item as it sits in the queue
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // queue status seen by the top level
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [4:0] action_index;
  } seq_status_t;

  // number of line actions for each command
  function automatic logic [4:0] seq_len(input logic [2:0] op);
    logic [4:0] len;
    case (op)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd25;
      OP_SACK:  len = 5'd3;
      OP_RACK:  len = 5'd4;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### src/i2cm_front.sv
// input side: unpacks and classifies tick items and queues them for the sequencer
module i2cm_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [2:0]                         s_axis_tuser,
  input  logic                               pop_i,
  output i2cm_pkg::item_t                    item_o,
  output i2cm_pkg::queue_status_t            qstat_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  i2cm_pkg::item_t   mem_q [QUEUE_DEPTH];
  i2cm_pkg::item_t   item_in;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push;
  logic              pop;

  // classify the incoming item
  always_comb begin
    item_in.opcode    = s_axis_tuser;
    item_in.tx_byte   = s_axis_tdata[7:0];
    item_in.ack_level = s_axis_tdata[8];
    item_in.sda_in    = s_axis_tdata[9];
    item_in.is_cmd    = (s_axis_tuser != i2cm_pkg::OP_NONE) &&
                        (s_axis_tuser <= i2cm_pkg::OP_RACK);
  end

  assign s_axis_tready = (count_q != CNT_FULL);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (count_q != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign item_o        = mem_q[rd_ptr_q];
  assign qstat_o.valid = (count_q != '0);
  assign qstat_o.full  = (count_q == CNT_FULL);

endmodule

### src/i2cm_back.sv
// sequencer: runs the line actions of each command, one tick item per cycle while the output is not stalled
module i2cm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [i2cm_pkg::TPA_W-1:0]          tpa_i,
  input  i2cm_pkg::item_t                     item_i,
  input  i2cm_pkg::queue_status_t             qstat_i,
  output logic                                pop_o,
  output i2cm_pkg::seq_status_t               sstat_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned TW = i2cm_pkg::TPA_W;

  logic [2:0]    cmd_q, cmd_d;
  logic [4:0]    idx_q, idx_d;
  logic [TW-1:0] tc_q, tc_d;
  logic [1:0]    ph_q, ph_d;
  logic [2:0]    bit_q, bit_d;
  logic [7:0]    shift_q, shift_d;
  logic          ack_q, ack_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic [7:0]    tx_q, tx_d;
  logic          ackl_q, ackl_d;
  logic          rej;
  logic          done;
  logic [TW:0]   tpa_eff;
  logic          last_tick;
  logic          m_valid_q;
  logic [i2cm_pkg::OUT_DATA_W-1:0] m_data_q;

  // take the next item when the output slot is free or being emptied
  assign pop_o = qstat_i.valid && (!m_valid_q || m_axis_tready);

  assign tpa_eff = (tpa_i == '0) ? (TW+1)'(1) : {1'b0, tpa_i};

  // one tick of the sequencer
  always_comb begin
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    tc_d      = tc_q;
    ph_d      = ph_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    tx_d      = tx_q;
    ackl_d    = ackl_q;
    rej       = 1'b0;
    done      = 1'b0;
    last_tick = 1'b0;

    // command acceptance or rejection
    if (cmd_q != i2cm_pkg::OP_NONE) begin
      rej = item_i.is_cmd;
    end else if (item_i.is_cmd) begin
      cmd_d = item_i.opcode;
      idx_d = '0;
      tc_d  = '0;
      ph_d  = '0;
      bit_d = '0;
      if (item_i.opcode == i2cm_pkg::OP_WRITE) tx_d = item_i.tx_byte;
      if (item_i.opcode == i2cm_pkg::OP_SACK) ackl_d = item_i.ack_level;
      if (item_i.opcode == i2cm_pkg::OP_READ) shift_d = '0;
    end

    if (cmd_d != i2cm_pkg::OP_NONE) begin
      // line action on the first tick of each action
      if (tc_d == '0) begin
        case (cmd_d)
          i2cm_pkg::OP_START: begin
            if (idx_d == 5'd0) sda_d = 1'b1;
            else if (idx_d == 5'd1) scl_d = 1'b1;
            else if (idx_d == 5'd2) sda_d = 1'b0;
            else scl_d = 1'b0;
          end
          i2cm_pkg::OP_STOP: begin
            if (idx_d == 5'd0) sda_d = 1'b0;
            else if (idx_d == 5'd1) scl_d = 1'b1;
            else sda_d = 1'b1;
          end
          i2cm_pkg::OP_WRITE: begin
            if (ph_d == 2'd0) sda_d = tx_d[3'd7 - bit_d];
            else if (ph_d == 2'd1) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
          i2cm_pkg::OP_READ: begin
            if (idx_d == 5'd0) begin
              sda_d = 1'b1;
            end else if (ph_d == 2'd0) begin
              scl_d = 1'b1;
            end else if (ph_d == 2'd1) begin
              if (item_i.sda_in) shift_d[3'd7 - bit_d] = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end
          i2cm_pkg::OP_SACK: begin
            if (idx_d == 5'd0) sda_d = ackl_d;
            else if (idx_d == 5'd1) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
          i2cm_pkg::OP_RACK: begin
            if (idx_d == 5'd0) sda_d = 1'b1;
            else if (idx_d == 5'd1) scl_d = 1'b1;
            else if (idx_d == 5'd2) ack_d = item_i.sda_in;
            else scl_d = 1'b0;
          end
          default: begin
          end
        endcase
      end

      // tick count and action advance
      last_tick = (({1'b0, tc_d} + (TW+1)'(1)) >= tpa_eff);
      if (last_tick) begin
        tc_d = '0;
        if (!((cmd_d == i2cm_pkg::OP_READ) && (idx_d == 5'd0))) begin
          if (ph_d == 2'd2) begin
            ph_d  = '0;
            bit_d = bit_d + 1'b1;
          end else begin
            ph_d = ph_d + 1'b1;
          end
        end
        idx_d = idx_d + 1'b1;
        if (idx_d >= i2cm_pkg::seq_len(cmd_d)) begin
          cmd_d = i2cm_pkg::OP_NONE;
          idx_d = '0;
          done  = 1'b1;
        end
      end else begin
        tc_d = tc_d + 1'b1;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= i2cm_pkg::OP_NONE;
      idx_q   <= '0;
      tc_q    <= '0;
      ph_q    <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      ack_q   <= 1'b1;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      tx_q    <= '0;
      ackl_q  <= 1'b0;
    end else if (pop_o) begin
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      tc_q    <= tc_d;
      ph_q    <= ph_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      tx_q    <= tx_d;
      ackl_q  <= ackl_d;
    end
  end

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pop_o) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_data_q <= {2'b00, rej, ack_d, shift_d, done,
                   (cmd_d != i2cm_pkg::OP_NONE), sda_d, scl_d};
    end
  end

  assign m_axis_tvalid        = m_valid_q;
  assign m_axis_tdata         = m_data_q;
  assign sstat_o.busy         = (cmd_q != i2cm_pkg::OP_NONE);
  assign sstat_o.action_index = idx_q;

endmodule

### src/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: register, tick queue and sequencer
//
// usage: every item on the slave stream is one tick of the bus timing base and
// may carry a command (start, stop, write byte, read byte, send ack, receive
// ack). each accepted item yields exactly one result item on the master stream
// with the scl/sda drives, busy, done, the received byte and ack, and a flag
// for a command that arrived while a command was still running (ignored).
// each line action lasts ticks_per_action ticks, set through cfg_we_i and
// cfg_wdata_i while the engine is idle; zero acts as one.
// a result passes two registers on its way: the item is written into the queue and
// then into the output item register. throughput: one item per cycle while the
// receiver takes results, set by the sequencer, which updates its state once per item.
// the small queue between the input side and the sequencer keeps s_axis_tready
// high while a result waits to be taken; when the receiver holds m_axis_tready
// low the queue fills and s_axis_tready drops once it is full.
// reset: queue empty, no command active, lines released, rx_ack reads one,
// rx_byte zero, ticks_per_action 720.
module i2c_master_bit_engine #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,      // ticks_per_action
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,     // tx_byte[7:0], ack_level[8], sda_in[9]
  input  logic [2:0]  s_axis_tuser,     // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata      // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                        // rx_byte[11:4], rx_ack[12], rejected[13]
);

  logic [i2cm_pkg::TPA_W-1:0] tpa_q;
  i2cm_pkg::item_t            item;
  i2cm_pkg::queue_status_t    qstat;
  i2cm_pkg::seq_status_t      sstat;
  logic                       pop;

  // action length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpa_q <= i2cm_pkg::TPA_RESET;
    end else if (cfg_we_i) begin
      tpa_q <= cfg_wdata_i;
    end
  end

  i2cm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .item_o        (item),
    .qstat_o       (qstat)
  );

  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tpa_i         (tpa_q),
    .item_i        (item),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .sstat_o       (sstat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // a finished command never reports busy in the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done and busy set in the same result item");

  // the input side only stalls when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> qstat.full && qstat.valid)
    else $error("input stalled with room in the queue");

  // an idle sequencer sits at the first action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sstat.busy |-> sstat.action_index == 5'd0)
    else $error("idle sequencer with a nonzero action index");

  // a result is produced only after an item was taken from the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop))
    else $error("result item without a queued tick item");

endmodule

### tb/i2c_line_checker.sv
// line checker for the i2c master bit engine: predicts each result item and compares it
module i2c_line_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // ticks_per_action
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // tx_byte[7:0], ack_level[8], sda_in[9]
  input  logic [2:0]  s_axis_tuser,    // opcode[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,    // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                       // rx_byte[11:4], rx_ack[12], rejected[13]
  output int          mismatches_o,
  output int          results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one tick item as carried on the slave stream, opcode from tuser lowest
  typedef struct packed {
    logic [5:0] pad;
    logic       sda_in;
    logic       ack_level;
    logic [7:0] tx_byte;
    logic [2:0] opcode;
  } tick_item_t;

  // one line result as packed on the master stream
  typedef struct packed {
    logic [1:0] pad;
    logic       rejected;
    logic       rx_ack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } line_result_t;

  // predicted engine state
  logic [15:0]  ticks_cfg;
  logic [2:0]   run_cmd;
  logic [4:0]   action_no;
  logic [15:0]  tick_no;
  logic [7:0]   rx_shift;
  logic         ack_bit;
  logic         scl_q;
  logic         sda_q;
  logic [7:0]   tx_hold;
  logic         ack_hold;
  line_result_t line_results_due[$];
  int           mismatches = 0;

  assign mismatches_o = mismatches;

  // line actions making up each command
  function automatic int actions_in(input logic [2:0] cmd);
    case (cmd)
      i2cm_pkg::OP_START: return 4;
      i2cm_pkg::OP_STOP:  return 3;
      i2cm_pkg::OP_WRITE: return 24;
      i2cm_pkg::OP_READ:  return 25;
      i2cm_pkg::OP_SACK:  return 3;
      i2cm_pkg::OP_RACK:  return 4;
      default:            return 0;
    endcase
  endfunction

  // perform action k of the running command
  function automatic void line_action(input logic [4:0] k, input logic sda_in);
    logic [4:0] bit_no;
    logic [4:0] phase;
    bit_no = '0;
    phase  = '0;
    case (run_cmd)
      i2cm_pkg::OP_START: begin
        case (k)
          5'd0:    sda_q = 1'b1;
          5'd1:    scl_q = 1'b1;
          5'd2:    sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      i2cm_pkg::OP_STOP: begin
        case (k)
          5'd0:    sda_q = 1'b0;
          5'd1:    scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end
      i2cm_pkg::OP_WRITE: begin
        bit_no = k / 5'd3;
        phase  = k % 5'd3;
        case (phase)
          5'd0:    sda_q = tx_hold[3'd7 - bit_no[2:0]];
          5'd1:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      i2cm_pkg::OP_READ: begin
        if (k == 5'd0) begin
          sda_q = 1'b1;
        end else begin
          bit_no = (k - 5'd1) / 5'd3;
          phase  = (k - 5'd1) % 5'd3;
          case (phase)
            5'd0: scl_q = 1'b1;
            5'd1: if (sda_in) rx_shift[3'd7 - bit_no[2:0]] = 1'b1;
            default: scl_q = 1'b0;
          endcase
        end
      end
      i2cm_pkg::OP_SACK: begin
        case (k)
          5'd0:    sda_q = ack_hold;
          5'd1:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      i2cm_pkg::OP_RACK: begin
        case (k)
          5'd0:    sda_q = 1'b1;
          5'd1:    scl_q = 1'b1;
          5'd2:    ack_bit = sda_in;
          default: scl_q = 1'b0;
        endcase
      end
      default: ;
    endcase
  endfunction

  // advance the engine by one tick and give the line result it produces
  function automatic line_result_t next_tick(input tick_item_t item);
    line_result_t res;
    logic         is_cmd;
    logic [15:0]  span;
    res    = '0;
    is_cmd = (item.opcode >= i2cm_pkg::OP_START) && (item.opcode <= i2cm_pkg::OP_RACK);
    span   = (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg;
    // a command is taken only while idle, otherwise flagged
    if (run_cmd != i2cm_pkg::OP_NONE) begin
      res.rejected = is_cmd;
    end else if (is_cmd) begin
      run_cmd   = item.opcode;
      action_no = '0;
      tick_no   = '0;
      if (item.opcode == i2cm_pkg::OP_WRITE) tx_hold = item.tx_byte;
      if (item.opcode == i2cm_pkg::OP_SACK) ack_hold = item.ack_level;
      if (item.opcode == i2cm_pkg::OP_READ) rx_shift = '0;
    end
    // action on the first tick of each slot, then count the slot out
    if (run_cmd != i2cm_pkg::OP_NONE) begin
      if (tick_no == 16'd0) line_action(action_no, item.sda_in);
      if ({1'b0, tick_no} + 17'd1 >= {1'b0, span}) begin
        tick_no   = '0;
        action_no = action_no + 5'd1;
        if (action_no >= actions_in(run_cmd)) begin
          run_cmd      = i2cm_pkg::OP_NONE;
          action_no    = '0;
          res.done_res = 1'b1;
        end
      end else begin
        tick_no = tick_no + 16'd1;
      end
    end
    res.scl_out  = scl_q;
    res.sda_out  = sda_q;
    res.busy_res = (run_cmd != i2cm_pkg::OP_NONE);
    res.rx_byte  = rx_shift;
    res.rx_ack   = ack_bit;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_result(input line_result_t got, input line_result_t want);
    if (got.scl_out !== want.scl_out)
      report_mismatch($sformatf("scl_out got %b expected %b", got.scl_out, want.scl_out));
    if (got.sda_out !== want.sda_out)
      report_mismatch($sformatf("sda_out got %b expected %b", got.sda_out, want.sda_out));
    if (got.busy_res !== want.busy_res)
      report_mismatch($sformatf("busy_res got %b expected %b", got.busy_res, want.busy_res));
    if (got.done_res !== want.done_res)
      report_mismatch($sformatf("done_res got %b expected %b", got.done_res, want.done_res));
    if (got.rx_byte !== want.rx_byte)
      report_mismatch($sformatf("rx_byte got %h expected %h", got.rx_byte, want.rx_byte));
    if (got.rx_ack !== want.rx_ack)
      report_mismatch($sformatf("rx_ack got %b expected %b", got.rx_ack, want.rx_ack));
    if (got.rejected !== want.rejected)
      report_mismatch($sformatf("rejected got %b expected %b", got.rejected, want.rejected));
  endtask

  // watch config, input items and result items
  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    if (!rst_ni) begin
      ticks_cfg = i2cm_pkg::TPA_RESET;
      run_cmd   = i2cm_pkg::OP_NONE;
      action_no = '0;
      tick_no   = '0;
      rx_shift  = '0;
      ack_bit   = 1'b1;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      tx_hold   = '0;
      ack_hold  = 1'b0;
      line_results_due.delete();
      results_due_o <= 0;
    end else begin
      if (cfg_we_i) ticks_cfg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        line_results_due.push_back(next_tick(tick_item_t'({s_axis_tdata, s_axis_tuser})));
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_results_due.size() == 0) begin
          report_mismatch("result item with none expected");
        end else begin
          want = line_results_due.pop_front();
          compare_result(line_result_t'(m_axis_tdata), want);
        end
      end
      results_due_o <= line_results_due.size();
    end
  end

endmodule

### tb/i2c_master_bit_engine_test.sv
// top of the i2c master bit engine test: clock, reset, stimulus, receiver and verdict
module i2c_master_bit_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED    = 3'd7;
  localparam int         HOLD_CYCLES  = 120;
  localparam int         QUIET_LIMIT  = 3000;
  localparam int         SETTLE_TICKS = 8;

  typedef enum logic [1:0] {PIN_RANDOM, PIN_LOW, PIN_HIGH} pin_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  int          mismatches;
  int          results_due;
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_request;
  int          items_sent;
  int          span;
  int          quiet_cycles;

  always #2 clk_i = ~clk_i;

  i2c_master_bit_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  i2c_line_checker line_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  // tdata bits above the opcode, opcode in the lowest three bits
  function automatic logic [18:0] pack_tick(input logic [2:0] op, input logic [7:0] tx,
                                            input logic ack, input logic sda);
    return {6'b000000, sda, ack, tx, op};
  endfunction

  function automatic logic pin_level(input pin_mode_e pins);
    case (pins)
      PIN_LOW:  return 1'b0;
      PIN_HIGH: return 1'b1;
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  // offer one tick item and wait until it is taken
  task automatic send_tick(input logic [18:0] data);
    if (src_gaps) begin
      while ($urandom_range(99) < 33) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= data[2:0];
    s_axis_tdata  <= data[18:3];
    items_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // idle ticks, some with the unused opcode
  task automatic idle_ticks(input int count);
    repeat (count)
      send_tick(pack_tick(($urandom_range(3) == 0) ? OP_UNUSED : i2cm_pkg::OP_NONE,
                          8'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // one command followed by the ticks that carry it to its done tick
  task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                             input pin_mode_e pins, input bit noisy);
    int         fillers;
    logic [2:0] extra_op;
    fillers = int'(i2cm_pkg::seq_len(op)) * span - 1;
    send_tick(pack_tick(op, tx, ack, pin_level(pins)));
    for (int i = 0; i < fillers; i++) begin
      extra_op = i2cm_pkg::OP_NONE;
      if (noisy) begin
        // commands while busy, sometimes right on the done tick
        if (i == fillers - 1 && $urandom_range(9) == 0)
          extra_op = 3'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_RACK));
        else if ($urandom_range(29) == 0)
          extra_op = 3'($urandom_range(i2cm_pkg::OP_START, OP_UNUSED));
      end
      send_tick(pack_tick(extra_op, 8'($urandom), 1'($urandom), pin_level(pins)));
    end
  endtask

  // a bus transfer: start, address, data bytes, stop
  task automatic run_transfer();
    run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, PIN_RANDOM, 1'b1);
    run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'b0, PIN_RANDOM, 1'b1);
    run_command(i2cm_pkg::OP_RACK, 8'h00, 1'b0, PIN_RANDOM, 1'b1);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(1) == 0) begin
        run_command(i2cm_pkg::OP_READ, 8'h00, 1'b0, PIN_RANDOM, 1'b1);
        run_command(i2cm_pkg::OP_SACK, 8'($urandom), 1'($urandom), PIN_RANDOM, 1'b1);
      end else begin
        run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'b0, PIN_RANDOM, 1'b1);
        run_command(i2cm_pkg::OP_RACK, 8'h00, 1'b0, PIN_RANDOM, 1'b1);
      end
    end
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, PIN_RANDOM, 1'b1);
  endtask

  // random traffic, mostly well-formed transfers
  task automatic run_traffic(input int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8)
        run_transfer();
      else
        run_command(3'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_RACK)),
                    8'($urandom), 1'($urandom), PIN_RANDOM, 1'b1);
      idle_ticks($urandom_range(0, 2));
    end
  endtask

  // stop offering and wait until every result item is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  // write ticks_per_action while the engine is idle
  task automatic set_ticks(input logic [15:0] value);
    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span = (value == 16'd0) ? 1 : int'(value);
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= sink_gaps ? ($urandom_range(99) >= 33) : 1'b1;
    end
  end

  // watchdog on cycles with no item moving
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    src_gaps      = 1'b0;
    sink_gaps     = 1'b0;
    hold_request  = 1'b0;
    items_sent    = 0;
    span          = int'(i2cm_pkg::TPA_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset state seen through idle ticks
    idle_ticks(3);

    // directed commands at the shortest action length
    set_ticks(16'd1);
    run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_RACK, 8'h00, 1'b0, PIN_LOW, 1'b0);
    run_command(i2cm_pkg::OP_WRITE, 8'h00, 1'b0, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_RACK, 8'h00, 1'b0, PIN_HIGH, 1'b0);
    run_command(i2cm_pkg::OP_READ, 8'h00, 1'b0, PIN_HIGH, 1'b0);
    run_command(i2cm_pkg::OP_SACK, 8'h00, 1'b0, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_READ, 8'hFF, 1'b1, PIN_LOW, 1'b0);
    run_command(i2cm_pkg::OP_SACK, 8'h00, 1'b1, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_READ, 8'h00, 1'b0, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_WRITE, 8'hA5, 1'b1, PIN_RANDOM, 1'b0);
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, PIN_RANDOM, 1'b0);
    // unused opcode while idle
    send_tick(pack_tick(OP_UNUSED, 8'h5A, 1'b1, 1'b1));
    // command while busy, then one on the done tick of start
    send_tick(pack_tick(i2cm_pkg::OP_START, 8'h00, 1'b0, 1'b0));
    send_tick(pack_tick(i2cm_pkg::OP_WRITE, 8'h3C, 1'b1, 1'b0));
    send_tick(pack_tick(i2cm_pkg::OP_NONE, 8'h00, 1'b0, 1'b1));
    send_tick(pack_tick(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 1'b0));
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, PIN_RANDOM, 1'b0);

    // zero length acts as one
    set_ticks(16'd0);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    run_traffic(200);

    // receiver holds off so the engine backs up
    set_ticks(16'd2);
    hold_request = 1'b1;
    run_traffic(330);

    // long stretch with no idling on either side
    set_ticks(16'd3);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    run_traffic(250);

    set_ticks(16'd1);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    run_traffic(330);

    set_ticks(16'd5);
    run_traffic(200);

    // longest action length, only the opening ticks of one command
    set_ticks(16'hFFFF);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_tick(pack_tick(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 1'b1));
    idle_ticks(20);

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
